// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks of the GLL field extractor.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define NGLL_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define NGLL_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/ngll_pkg.sv =====
// ---------------------------------------------------------------------------
// ngll_pkg
// Types, character codes and limits shared by the GLL field extractor.
// ---------------------------------------------------------------------------
package ngll_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;

    // Sentence header "$GPGLL", padded to the index range
    localparam int unsigned HEADER_LEN = 6;
    localparam logic [7:0] HDR_TEXT [8] = '{
        8'h24, 8'h47, 8'h50, 8'h47, 8'h4C, 8'h4C, 8'h00, 8'h00
    };

    // Field widths and saturation limits
    localparam int unsigned LAT_W  = 30;
    localparam int unsigned LON_W  = 34;
    localparam int unsigned CHAR_W = 8;
    localparam logic [LAT_W-1:0] LAT_MAX = 30'd999999999;
    localparam logic [LON_W-1:0] LON_MAX = 34'd9999999999;

    // Field position within the sentence
    typedef enum logic [2:0] {
        FLD_HUNT,
        FLD_SKIP,
        FLD_LAT,
        FLD_NS,
        FLD_LON,
        FLD_EW,
        FLD_TIME,
        FLD_STATUS
    } t_field;

    // Coordinate accumulator, kept already scaled to the fixed-point unit
    typedef struct packed {
        logic [LON_W-1:0] acc;
        logic [2:0]       frac_cnt;
        logic             in_frac;
        logic             stopped;
    } t_coord;

    // One extracted sentence
    typedef struct packed {
        logic [LAT_W-1:0]  latitude_scaled;
        logic [CHAR_W-1:0] north_south;
        logic [LON_W-1:0]  longitude_scaled;
        logic [CHAR_W-1:0] east_west;
        logic [CHAR_W-1:0] status_char;
        logic              fix_valid;
        logic              range_flag;
    } t_result;

    // Powers of ten for digit weights
    function automatic logic [23:0] ngll_pow10(input logic [2:0] e);
        logic [23:0] p;
        unique case (e)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            default: p = 24'd10000000;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/ngll_coord_acc.sv =====
// ---------------------------------------------------------------------------
// ngll_coord_acc
// One-byte update of a decimal coordinate, held directly in scaled units
// and saturated to the latitude or longitude limit.
// ---------------------------------------------------------------------------
module ngll_coord_acc import ngll_pkg::*; #(
    parameter int FRACTION_DIGITS = 5
) (
    input  logic [7:0] i_byte,
    input  logic       i_lon_sel,
    input  t_coord     i_cur,
    output t_coord     o_nxt,
    output logic       o_sat
);

    logic        is_digit;
    logic        frac_full;
    logic [3:0]  dval;
    logic [2:0]  expo;
    logic [27:0] addend;
    logic [37:0] base;
    logic [37:0] sum;
    logic [37:0] limit;

    // Digit weight: integer digits shift the value up, fraction digits add
    // at a falling power of ten
    always_comb begin
        is_digit  = (i_byte >= CH_0) && (i_byte <= CH_9);
        dval      = 4'(i_byte - CH_0);
        frac_full = i_cur.frac_cnt >= 3'(FRACTION_DIGITS);
        expo      = i_cur.in_frac ? 3'(FRACTION_DIGITS - 1 - int'(i_cur.frac_cnt))
                                  : 3'(FRACTION_DIGITS);
        addend    = 28'(dval) * 28'(ngll_pow10(expo));
        base      = i_cur.in_frac ? 38'(i_cur.acc)
                                  : (38'(i_cur.acc) << 3) + (38'(i_cur.acc) << 1);
        sum       = base + 38'(addend);
        limit     = i_lon_sel ? 38'(LON_MAX) : 38'(LAT_MAX);
    end

    // Next accumulator state
    always_comb begin
        o_nxt = i_cur;
        o_sat = 1'b0;
        if (!i_cur.stopped) begin
            if (is_digit) begin
                // extra fraction digits are dropped
                if (!(i_cur.in_frac && frac_full)) begin
                    if (i_cur.in_frac) begin
                        o_nxt.frac_cnt = i_cur.frac_cnt + 3'd1;
                    end
                    if (sum > limit) begin
                        o_nxt.acc = LON_W'(limit);
                        o_sat     = 1'b1;
                    end else begin
                        o_nxt.acc = sum[LON_W-1:0];
                    end
                end
            end else if (i_byte == CH_DOT && !i_cur.in_frac) begin
                o_nxt.in_frac = 1'b1;
            end else begin
                o_nxt.stopped = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/ngll_parser.sv =====
// ---------------------------------------------------------------------------
// ngll_parser
// Header match, field sequencing and per-sentence holding registers.
// ---------------------------------------------------------------------------
module ngll_parser import ngll_pkg::*; #(
    parameter int FRACTION_DIGITS = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_emit,
    output t_result    o_result
);

    t_field            r_field,      n_field;
    logic [2:0]        r_hdr_idx,    n_hdr_idx;
    t_coord            r_coord,      n_coord;
    logic              r_first,      n_first;
    logic [LAT_W-1:0]  r_lat_hold,   n_lat_hold;
    logic [LON_W-1:0]  r_lon_hold,   n_lon_hold;
    logic [CHAR_W-1:0] r_ns_hold,    n_ns_hold;
    logic [CHAR_W-1:0] r_ew_hold,    n_ew_hold;
    logic [CHAR_W-1:0] r_status,     n_status;
    logic              r_sat,        n_sat;

    t_coord            coord_nxt;
    logic              coord_sat;
    logic              hdr_hit;
    logic              hdr_done;

    ngll_coord_acc #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_coord (
        .i_byte    (i_byte),
        .i_lon_sel (r_field == FLD_LON),
        .i_cur     (r_coord),
        .o_nxt     (coord_nxt),
        .o_sat     (coord_sat)
    );

    // Header byte comparison
    always_comb begin
        hdr_hit  = (r_field == FLD_HUNT) && (32'(r_hdr_idx) < HEADER_LEN)
                   && (i_byte == HDR_TEXT[r_hdr_idx]);
        hdr_done = hdr_hit && (32'(r_hdr_idx) == HEADER_LEN - 1);
    end

    // Next field and header position
    always_comb begin
        n_field   = r_field;
        n_hdr_idx = r_hdr_idx;
        priority if (i_byte == CH_NUL) begin
            n_field   = FLD_HUNT;
            n_hdr_idx = 3'd0;
        end else if (i_byte == CH_DOLLAR) begin
            n_field   = FLD_HUNT;
            n_hdr_idx = 3'd1;
        end else if (r_field == FLD_HUNT) begin
            if (hdr_done) begin
                n_field   = FLD_SKIP;
                n_hdr_idx = 3'd0;
            end else if (hdr_hit) begin
                n_hdr_idx = r_hdr_idx + 3'd1;
            end else begin
                n_hdr_idx = 3'd0;
            end
        end else if (i_byte == CH_COMMA) begin
            unique case (r_field)
                FLD_SKIP:   n_field = FLD_LAT;
                FLD_LAT:    n_field = FLD_NS;
                FLD_NS:     n_field = FLD_LON;
                FLD_LON:    n_field = FLD_EW;
                FLD_EW:     n_field = FLD_TIME;
                FLD_TIME:   n_field = FLD_STATUS;
                FLD_STATUS: begin
                    n_field   = FLD_HUNT;
                    n_hdr_idx = 3'd0;
                end
                default:    n_field = FLD_HUNT;
            endcase
        end else begin
            // field contents leave the position alone
            n_field = r_field;
        end
    end

    // Field data, holds and result request
    always_comb begin
        n_coord    = r_coord;
        n_first    = r_first;
        n_lat_hold = r_lat_hold;
        n_lon_hold = r_lon_hold;
        n_ns_hold  = r_ns_hold;
        n_ew_hold  = r_ew_hold;
        n_status   = r_status;
        n_sat      = r_sat;
        o_emit     = 1'b0;

        priority if (i_byte == CH_NUL || i_byte == CH_DOLLAR || hdr_done) begin
            // new or dropped sentence
            n_coord    = '0;
            n_first    = 1'b0;
            n_status   = '0;
            n_lat_hold = '0;
            n_lon_hold = '0;
            n_ns_hold  = '0;
            n_ew_hold  = '0;
            n_sat      = 1'b0;
        end else if (r_field == FLD_HUNT) begin
            n_coord = r_coord;
        end else if (i_byte != CH_COMMA) begin
            unique case (r_field)
                FLD_LAT, FLD_LON: begin
                    n_coord = coord_nxt;
                    if (coord_sat) begin
                        n_sat = 1'b1;
                    end
                end
                FLD_NS: begin
                    if (!r_first) begin
                        n_ns_hold = i_byte;
                        n_first   = 1'b1;
                    end
                end
                FLD_EW: begin
                    if (!r_first) begin
                        n_ew_hold = i_byte;
                        n_first   = 1'b1;
                    end
                end
                FLD_STATUS: begin
                    if (!r_first) begin
                        n_status = i_byte;
                        n_first  = 1'b1;
                    end
                end
                default: n_first = r_first;
            endcase
        end else begin
            // comma closes the field; scaled value is already final
            if (r_field == FLD_LAT) begin
                n_lat_hold = r_coord.acc[LAT_W-1:0];
            end
            if (r_field == FLD_LON) begin
                n_lon_hold = r_coord.acc;
            end
            n_coord  = '0;
            n_first  = 1'b0;
            n_status = '0;
            if (r_field == FLD_STATUS) begin
                o_emit     = 1'b1;
                n_lat_hold = '0;
                n_lon_hold = '0;
                n_ns_hold  = '0;
                n_ew_hold  = '0;
                n_sat      = 1'b0;
            end
        end
    end

    // Result as seen when the closing comma arrives
    always_comb begin
        o_result.latitude_scaled  = r_lat_hold;
        o_result.north_south      = r_ns_hold;
        o_result.longitude_scaled = r_lon_hold;
        o_result.east_west        = r_ew_hold;
        o_result.status_char      = r_status;
        o_result.fix_valid        = (r_status == CH_A);
        o_result.range_flag       = r_sat;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field    <= FLD_HUNT;
            r_hdr_idx  <= 3'd0;
            r_coord    <= '0;
            r_first    <= 1'b0;
            r_lat_hold <= '0;
            r_lon_hold <= '0;
            r_ns_hold  <= '0;
            r_ew_hold  <= '0;
            r_status   <= '0;
            r_sat      <= 1'b0;
        end else if (i_step) begin
            r_field    <= n_field;
            r_hdr_idx  <= n_hdr_idx;
            r_coord    <= n_coord;
            r_first    <= n_first;
            r_lat_hold <= n_lat_hold;
            r_lon_hold <= n_lon_hold;
            r_ns_hold  <= n_ns_hold;
            r_ew_hold  <= n_ew_hold;
            r_status   <= n_status;
            r_sat      <= n_sat;
        end
    end

endmodule

// ===== rtl/nmea_gll_field_extractor.sv =====
// ---------------------------------------------------------------------------
// nmea_gll_field_extractor
// Extracts position, hemisphere and status fields from GLL sentences.
// ---------------------------------------------------------------------------
// Usage:
//   Receive channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one ASCII
//   byte per request. Result channel (o_res_valid / i_res_ready) presents one
//   request per complete sentence, raised by the comma after the status field.
//   Coordinates come out as unsigned fixed point scaled by 10^FRACTION_DIGITS
//   and saturated; o_range_flag marks a saturated coordinate.
//   Result path: o_res_valid rises once the closing comma has passed the input
//   register and the parse stage into the result register, delayed only while
//   an earlier result still waits.
//   Throughput: one byte per cycle unless a byte is stalled as below, set by
//   the single parse stage between the input register and the result register.
//   Stall: a waiting result does not stop bytes that raise no result; only a
//   byte that completes a sentence waits in the input register until the
//   result register is free, and o_rx_ready drops behind it.
//   Reset: returns to the header hunt with no sentence in progress and both
//   channels empty.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nmea_gll_field_extractor import ngll_pkg::*; #(
    parameter int FRACTION_DIGITS = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [LAT_W-1:0]  o_latitude_scaled,
    output logic [CHAR_W-1:0] o_north_south,
    output logic [LON_W-1:0]  o_longitude_scaled,
    output logic [CHAR_W-1:0] o_east_west,
    output logic [CHAR_W-1:0] o_status_char,
    output logic              o_fix_valid,
    output logic              o_range_flag
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    t_result    r_out;

    t_result    result;
    logic       emit_req;
    logic       out_free;
    logic       fire;
    logic       in_take;

    logic       chk_fix;
    logic       chk_range;
    logic       emit_fire;
    logic       in_stall;

    // Handshake: a byte moves on unless it needs a full result register
    always_comb begin
        out_free   = !r_out_vld || i_res_ready;
        fire       = r_in_vld && (out_free || !emit_req);
        o_rx_ready = !r_in_vld || fire;
        in_take    = i_rx_valid && o_rx_ready;
    end

    ngll_parser #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (fire),
        .i_byte   (r_in_byte),
        .o_emit   (emit_req),
        .o_result (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire && emit_req) begin
            r_out_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit_req) begin
            r_out <= result;
        end
    end

    assign o_res_valid        = r_out_vld;
    assign o_latitude_scaled  = r_out.latitude_scaled;
    assign o_north_south      = r_out.north_south;
    assign o_longitude_scaled = r_out.longitude_scaled;
    assign o_east_west        = r_out.east_west;
    assign o_status_char      = r_out.status_char;
    assign o_fix_valid        = r_out.fix_valid;
    assign o_range_flag       = r_out.range_flag;

    // Check terms
    assign chk_fix   = (o_fix_valid == (o_status_char == CH_A));
    assign chk_range = (o_latitude_scaled <= LAT_MAX) && (o_longitude_scaled <= LON_MAX);
    assign emit_fire = fire && emit_req;
    assign in_stall  = r_in_vld && !fire;

    // Checks
    `NGLL_ASSERT_IMPL(a_fix_valid, i_clk, i_rst_n, o_res_valid, chk_fix, "fix flag mismatch")
    `NGLL_ASSERT_IMPL(a_coord_range, i_clk, i_rst_n, o_res_valid, chk_range, "coord over limit")
    `NGLL_ASSERT_IMPL(a_emit_space, i_clk, i_rst_n, emit_fire, out_free, "result reg occupied")
    `NGLL_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_stall, r_in_vld && $stable(r_in_byte), "byte lost")

endmodule
